[rtl/gswr_pkg.sv]
package gswr_pkg;

	localparam int IDX_W = 19;

	typedef logic signed [IDX_W-1:0] idx_t;

	typedef enum logic [2:0] {
		IX_ABSENT = 3'd0,
		IX_ABS    = 3'd1,
		IX_REL    = 3'd2,
		IX_DSTART = 3'd3,
		IX_DEND   = 3'd4,
		IX_NONNUM = 3'd5
	} code_t;

	typedef enum logic [2:0] {
		KIND_EMPTY   = 3'd0,
		KIND_COPY    = 3'd1,
		KIND_CELL    = 3'd2,
		KIND_WINDOW  = 3'd3,
		KIND_ILLEGAL = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		RS_FAIL    = 2'd0,
		RS_OK      = 2'd1,
		RS_ILLEGAL = 2'd2
	} stat_t;

	localparam logic [1:0] VK_EMPTY  = 2'd0;
	localparam logic [1:0] VK_SINGLE = 2'd1;
	localparam logic [1:0] VK_BAD    = 2'd3;

	typedef struct packed {
		stat_t stat;
		idx_t  pos;
	} res_t;

	typedef struct packed {
		stat_t stat;
		idx_t  s;
		idx_t  e;
	} range_t;

	// Stage 1 result: decided early or resolved ranges for both dimensions.
	typedef struct packed {
		logic        done;
		kind_t       kind;
		logic        single;
		logic [15:0] rows;
		logic [15:0] cols;
		logic [15:0] base_row;
		logic [15:0] base_col;
		range_t      rng_r;
		range_t      rng_c;
	} s1_t;

	// Stage 2 result: ranges clamped to the dimensions.
	typedef struct packed {
		logic        done;
		kind_t       kind;
		logic        single;
		logic [15:0] base_row;
		logic [15:0] base_col;
		idx_t        r0;
		idx_t        r1;
		idx_t        q0;
		idx_t        q1;
	} s2_t;

	function automatic res_t resolve_one(code_t code, logic signed [16:0] val,
		logic [15:0] len, logic [15:0] here);
		res_t r;
		idx_t vx;
		idx_t lx;
		idx_t cx;
		vx = {{(IDX_W-17){val[16]}}, val};
		lx = {{(IDX_W-16){1'b0}}, len};
		cx = {{(IDX_W-16){1'b0}}, here};
		r.stat = RS_OK;
		r.pos = '0;
		case (code)
			IX_ABS: begin
				r.pos = val[16] ? vx + lx : vx;
			end
			IX_REL: begin
				r.pos = cx + vx;
			end
			IX_DSTART: begin
				r.pos = '0;
			end
			IX_DEND: begin
				r.pos = lx;
			end
			IX_NONNUM: begin
				r.stat = RS_FAIL;
			end
			default: begin
				r.stat = RS_ILLEGAL;
			end
		endcase
		return r;
	endfunction

	function automatic range_t resolve_range(code_t sc, code_t ec,
		logic signed [16:0] sv, logic signed [16:0] ev,
		logic [15:0] len, logic [15:0] here);
		range_t rg;
		res_t rs;
		res_t re;
		idx_t cx;
		cx = {{(IDX_W-16){1'b0}}, here};
		rs = resolve_one(sc, sv, len, here);
		re = resolve_one(ec, ev, len, here);
		rg.stat = RS_OK;
		rg.s = '0;
		rg.e = '0;
		if (sc == IX_ABSENT) begin
			if (ec != IX_ABSENT) begin
				rg.stat = RS_ILLEGAL;
			end else if (len == 16'd1) begin
				rg.e = idx_t'(1);
			end else begin
				rg.s = cx;
				rg.e = cx + idx_t'(1);
			end
		end else if (rs.stat != RS_OK) begin
			// A start that fails hides whatever the end index holds.
			rg.stat = rs.stat;
		end else if (ec == IX_ABSENT) begin
			rg.s = rs.pos;
			rg.e = rs.pos + idx_t'(1);
		end else begin
			rg.stat = re.stat;
			rg.s = rs.pos;
			rg.e = re.pos;
		end
		return rg;
	endfunction

endpackage

[rtl/gswr_decode.sv]
module gswr_decode import gswr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  logic [1:0]         value_kind,
	input  logic [15:0]        value_rows,
	input  logic [15:0]        value_cols,
	input  logic [15:0]        window_base_row,
	input  logic [15:0]        window_base_col,
	input  logic [15:0]        here_row,
	input  logic [15:0]        here_col,
	input  logic [11:0]        index_kinds,
	input  logic signed [16:0] first_start_value,
	input  logic signed [16:0] first_end_value,
	input  logic signed [16:0] second_start_value,
	input  logic signed [16:0] second_end_value,
	output logic               valid_s1,
	output s1_t                data_s1
);

	code_t c0, c1, c2, c3;
	code_t rsc, rec, csc, cec;
	logic signed [16:0] rsv, rev, csv, cev;
	logic [15:0] rows, cols;
	s1_t nxt;

	assign c0 = code_t'(index_kinds[2:0]);
	assign c1 = code_t'(index_kinds[5:3]);
	assign c2 = code_t'(index_kinds[8:6]);
	assign c3 = code_t'(index_kinds[11:9]);

	always_comb begin
		nxt = '0;
		nxt.kind = KIND_EMPTY;
		nxt.single = (value_kind == VK_SINGLE);
		rows = nxt.single ? 16'd1 : value_rows;
		cols = nxt.single ? 16'd1 : value_cols;
		nxt.rows = rows;
		nxt.cols = cols;
		nxt.base_row = window_base_row;
		nxt.base_col = window_base_col;
		rsc = IX_ABSENT;
		rec = IX_ABSENT;
		csc = IX_ABSENT;
		cec = IX_ABSENT;
		rsv = '0;
		rev = '0;
		csv = '0;
		cev = '0;
		if (c0 == IX_ABSENT && c1 == IX_ABSENT) begin
			if (c2 != IX_ABSENT || c3 != IX_ABSENT) begin
				nxt.done = 1'b1;
				nxt.kind = KIND_ILLEGAL;
			end
		end else if (c2 == IX_ABSENT && c3 == IX_ABSENT) begin
			// A lone slice runs along the unit dimension; the other takes 0..1.
			if (rows == 16'd1) begin
				rsc = IX_ABS;
				rec = IX_ABS;
				rev = 17'sd1;
				csc = c0;
				csv = first_start_value;
				cec = c1;
				cev = first_end_value;
			end else if (cols == 16'd1) begin
				rsc = c0;
				rsv = first_start_value;
				rec = c1;
				rev = first_end_value;
				csc = IX_ABS;
				cec = IX_ABS;
				cev = 17'sd1;
			end else begin
				nxt.done = 1'b1;
				nxt.kind = KIND_EMPTY;
			end
		end else begin
			rsc = c0;
			rsv = first_start_value;
			rec = c1;
			rev = first_end_value;
			csc = c2;
			csv = second_start_value;
			cec = c3;
			cev = second_end_value;
		end
		// An empty or bad value kind overrides anything the slices decided.
		if (value_kind == VK_EMPTY) begin
			nxt.done = 1'b1;
			nxt.kind = KIND_EMPTY;
		end else if (value_kind == VK_BAD) begin
			nxt.done = 1'b1;
			nxt.kind = KIND_ILLEGAL;
		end
		nxt.rng_r = resolve_range(rsc, rec, rsv, rev, rows, here_row);
		nxt.rng_c = resolve_range(csc, cec, csv, cev, cols, here_col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

[rtl/gswr_clamp.sv]
module gswr_clamp import gswr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s1,
	input  s1_t  data_s1,
	output logic valid_s2,
	output s2_t  data_s2
);

	s2_t  nxt;
	idx_t len_r;
	idx_t len_c;

	assign len_r = {{(IDX_W-16){1'b0}}, data_s1.rows};
	assign len_c = {{(IDX_W-16){1'b0}}, data_s1.cols};

	always_comb begin
		nxt.done = data_s1.done;
		nxt.kind = data_s1.kind;
		nxt.single = data_s1.single;
		nxt.base_row = data_s1.base_row;
		nxt.base_col = data_s1.base_col;
		if (!data_s1.done) begin
			// Both dimensions are always resolved, so illegal beats a failure.
			if (data_s1.rng_r.stat == RS_ILLEGAL || data_s1.rng_c.stat == RS_ILLEGAL) begin
				nxt.done = 1'b1;
				nxt.kind = KIND_ILLEGAL;
			end else if (data_s1.rng_r.stat != RS_OK || data_s1.rng_c.stat != RS_OK) begin
				nxt.done = 1'b1;
				nxt.kind = KIND_EMPTY;
			end
		end
		nxt.r0 = data_s1.rng_r.s[IDX_W-1] ? '0 : data_s1.rng_r.s;
		nxt.q0 = data_s1.rng_c.s[IDX_W-1] ? '0 : data_s1.rng_c.s;
		nxt.r1 = (data_s1.rng_r.e > len_r) ? len_r : data_s1.rng_r.e;
		nxt.q1 = (data_s1.rng_c.e > len_c) ? len_c : data_s1.rng_c.e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt;
		end
	end

endmodule

[rtl/gswr_emit.sv]
module gswr_emit import gswr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        valid_s2,
	input  s2_t         data_s2,
	output logic        valid_s3,
	output logic [2:0]  kind_s3,
	output logic [16:0] row_s3,
	output logic [16:0] col_s3,
	output logic [15:0] rows_s3,
	output logic [15:0] cols_s3
);

	idx_t        diff_r;
	idx_t        diff_c;
	logic        is_empty;
	kind_t       kind;
	logic        keep;
	logic [16:0] row_sum;
	logic [16:0] col_sum;

	assign diff_r = data_s2.r1 - data_s2.r0;
	assign diff_c = data_s2.q1 - data_s2.q0;
	assign is_empty = diff_r[IDX_W-1] || (diff_r == '0) || diff_c[IDX_W-1] || (diff_c == '0);
	assign row_sum = {1'b0, data_s2.base_row} + data_s2.r0[16:0];
	assign col_sum = {1'b0, data_s2.base_col} + data_s2.q0[16:0];

	always_comb begin
		keep = 1'b0;
		if (data_s2.done) begin
			kind = data_s2.kind;
		end else if (is_empty) begin
			kind = KIND_EMPTY;
		end else if (data_s2.single) begin
			kind = KIND_COPY;
		end else begin
			keep = 1'b1;
			kind = (diff_r == idx_t'(1) && diff_c == idx_t'(1)) ? KIND_CELL : KIND_WINDOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	// Position and size fields read zero for anything but a cell or a window.
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind;
			row_s3 <= keep ? row_sum : '0;
			col_s3 <= keep ? col_sum : '0;
			rows_s3 <= keep ? diff_r[15:0] : '0;
			cols_s3 <= keep ? diff_c[15:0] : '0;
		end
	end

endmodule

[rtl/grid_slice_window_resolver.sv]
// Pipeline: each input transfer passes through the registered decode, clamp and emit stages.
// Throughput: one item per cycle unless stalled; each stage holds one item and moves
// on when the stage after it is empty or moving, so bubbles are squeezed out under stall.
// Reset: arst_n clears the three stage valid bits at once; payload registers keep
// whatever they hold and are never shown without a valid bit.
module grid_slice_window_resolver import gswr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         value_kind,
	input  logic [15:0]        value_rows,
	input  logic [15:0]        value_cols,
	input  logic [15:0]        window_base_row,
	input  logic [15:0]        window_base_col,
	input  logic [15:0]        here_row,
	input  logic [15:0]        here_col,
	input  logic [11:0]        index_kinds,
	input  logic signed [16:0] first_start_value,
	input  logic signed [16:0] first_end_value,
	input  logic signed [16:0] second_start_value,
	input  logic signed [16:0] second_end_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         result_kind,
	output logic [16:0]        out_row,
	output logic [16:0]        out_col,
	output logic [15:0]        out_rows,
	output logic [15:0]        out_cols
);

	logic valid_s1;
	logic valid_s2;
	logic en1;
	logic en2;
	logic en3;
	s1_t  data_s1;
	s2_t  data_s2;

	assign en3 = !out_valid || !out_stall;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_stall = !en1;

	gswr_decode u_decode (
		.clk                (clk),
		.arst_n             (arst_n),
		.en                 (en1),
		.valid_in           (in_valid),
		.value_kind         (value_kind),
		.value_rows         (value_rows),
		.value_cols         (value_cols),
		.window_base_row    (window_base_row),
		.window_base_col    (window_base_col),
		.here_row           (here_row),
		.here_col           (here_col),
		.index_kinds        (index_kinds),
		.first_start_value  (first_start_value),
		.first_end_value    (first_end_value),
		.second_start_value (second_start_value),
		.second_end_value   (second_end_value),
		.valid_s1           (valid_s1),
		.data_s1            (data_s1)
	);

	gswr_clamp u_clamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	gswr_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (out_valid),
		.kind_s3  (result_kind),
		.row_s3   (out_row),
		.col_s3   (out_col),
		.rows_s3  (out_rows),
		.cols_s3  (out_cols)
	);

	// The input side can only be held back when every stage is full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_valid && out_stall))
		else $error("input stalled while the pipeline has room");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind != KIND_CELL && result_kind != KIND_WINDOW)
		|-> (out_row == '0 && out_col == '0 && out_rows == '0 && out_cols == '0))
		else $error("position fields not zero for a non-window result");

	a_cell_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_CELL) |-> (out_rows == 16'd1 && out_cols == 16'd1))
		else $error("one-cell result with a size other than one by one");

	a_window_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_WINDOW) |-> (out_rows != '0 && out_cols != '0))
		else $error("window result with an empty dimension");

endmodule
